[design/indent_dedent_tracker_assert.svh]
`ifndef INDENT_DEDENT_TRACKER_ASSERT_SVH
`define INDENT_DEDENT_TRACKER_ASSERT_SVH

// checked on every clock edge once out of reset
`define ITDT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define ITDT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/itdt_pkg.sv]
package itdt_pkg;

  localparam int KIND_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE     = 3'd0,
    KIND_INDENT   = 3'd1,
    KIND_DEDENT   = 3'd2,
    KIND_ERROR    = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  last;
  } res_t;

endpackage

[design/itdt_mem.sv]
module itdt_mem #(
  parameter int STACK_DEPTH = 16,
  parameter int INDENT_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rd_en_i,
  input  logic [$clog2(STACK_DEPTH)-1:0] rd_addr_i,
  output logic [INDENT_BITS-1:0]         rd_data_o,
  input  logic                           wr_en_i,
  input  logic [$clog2(STACK_DEPTH)-1:0] wr_addr_i,
  input  logic [INDENT_BITS-1:0]         wr_data_i
);

  logic [INDENT_BITS-1:0] mem [STACK_DEPTH];
  logic [INDENT_BITS-1:0] rd_data_q;
  logic                   zero_q;

  // bottom level is always zero and never written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q <= 1'b1;
    end else if (rd_en_i) begin
      zero_q <= (rd_addr_i == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = zero_q ? '0 : rd_data_q;

endmodule

[design/itdt_ctrl.sv]
module itdt_ctrl #(
  parameter int STACK_DEPTH = 16,
  parameter int INDENT_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [INDENT_BITS-1:0]           line_indent_i,
  output logic                             rd_en_o,
  output logic [$clog2(STACK_DEPTH)-1:0]   rd_addr_o,
  input  logic [INDENT_BITS-1:0]           rd_data_i,
  output logic                             wr_en_o,
  output logic [$clog2(STACK_DEPTH)-1:0]   wr_addr_o,
  output logic [INDENT_BITS-1:0]           wr_data_o,
  output logic                             res_vld_o,
  output itdt_pkg::res_t                   res_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0] res_depth_o,
  input  logic                             res_rdy_i
);

  import itdt_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(STACK_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECIDE = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_POP    = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [INDENT_BITS-1:0] width_q, width_d;
  logic [INDENT_BITS-1:0] top_q, top_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [CNT_W-1:0]       tgt_q, tgt_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [CNT_W-1:0]       cnt_dec;

  assign cnt_dec = cnt_q - CNT_W'(1);

  always_comb begin
    state_d     = state_q;
    width_d     = width_q;
    top_d       = top_q;
    cnt_d       = cnt_q;
    tgt_d       = tgt_q;
    idx_d       = idx_q;
    in_stall_o  = 1'b1;
    rd_en_o     = 1'b0;
    rd_addr_o   = idx_q;
    wr_en_o     = 1'b0;
    wr_addr_o   = cnt_q[IDX_W-1:0];
    wr_data_o   = width_q;
    res_vld_o   = 1'b0;
    res_o.kind  = KIND_NONE;
    res_o.last  = 1'b1;
    res_depth_o = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          width_d = line_indent_i;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (width_q == top_q) begin
          res_vld_o = 1'b1;
          if (res_rdy_i) state_d = ST_IDLE;
        end else if (width_q > top_q) begin
          res_vld_o = 1'b1;
          if (cnt_q == FULL) begin
            res_o.kind = KIND_OVERFLOW;
            if (res_rdy_i) state_d = ST_IDLE;
          end else begin
            res_o.kind  = KIND_INDENT;
            res_depth_o = cnt_q + CNT_W'(1);
            if (res_rdy_i) begin
              wr_en_o = 1'b1;
              cnt_d   = cnt_q + CNT_W'(1);
              top_d   = width_q;
              state_d = ST_IDLE;
            end
          end
        end else begin
          // top is above zero here, so at least two levels are open
          idx_d     = IDX_W'(cnt_q - CNT_W'(2));
          rd_en_o   = 1'b1;
          rd_addr_o = idx_d;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_data_i == width_q) begin
          tgt_d   = CNT_W'(idx_q) + CNT_W'(1);
          state_d = ST_POP;
        end else if (rd_data_i < width_q) begin
          res_vld_o  = 1'b1;
          res_o.kind = KIND_ERROR;
          if (res_rdy_i) state_d = ST_IDLE;
        end else begin
          idx_d     = idx_q - IDX_W'(1);
          rd_en_o   = 1'b1;
          rd_addr_o = idx_d;
        end
      end
      ST_POP: begin
        res_vld_o   = 1'b1;
        res_o.kind  = KIND_DEDENT;
        res_o.last  = (cnt_dec == tgt_q);
        res_depth_o = cnt_dec;
        if (res_rdy_i) begin
          cnt_d = cnt_dec;
          if (cnt_dec == tgt_q) begin
            top_d   = width_q;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      top_q   <= '0;
      cnt_q   <= CNT_W'(1);
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    width_q <= width_d;
    tgt_q   <= tgt_d;
    idx_q   <= idx_d;
  end

endmodule

[design/itdt_out.sv]
module itdt_out #(
  parameter int CNT_W = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        res_vld_i,
  input  itdt_pkg::res_t              res_i,
  input  logic [CNT_W-1:0]            res_depth_i,
  output logic                        res_rdy_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [itdt_pkg::KIND_W-1:0] token_kind_o,
  output logic                        last_of_run_o,
  output logic [CNT_W-1:0]            open_depth_o
);

  import itdt_pkg::*;

  logic             vld_q, vld_d;
  res_t             res_q;
  logic [CNT_W-1:0] depth_q;
  logic             load;

  assign res_rdy_o = !vld_q || !out_stall_i;
  assign load      = res_vld_i && res_rdy_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q   <= res_i;
      depth_q <= res_depth_i;
    end
  end

  assign out_valid_o   = vld_q;
  assign token_kind_o  = res_q.kind;
  assign last_of_run_o = res_q.last;
  assign open_depth_o  = depth_q;

endmodule

[design/indent_dedent_tracker.sv]
// Offside-rule indentation tracker: each input item is the leading whitespace width of one
// source line; the block keeps the open indentation levels in a single-port-read stack memory
// (bottom level fixed at zero) and returns one none, indent, overflow or mismatch-error item,
// or a run of dedent items with the final one flagged by last_of_run_o, while open_depth_o
// gives the stack depth after each item. An item whose width equals or exceeds the top level
// gets its result in the decide state once the width is registered; a smaller width first
// scans the stored levels down from the top (one memory read per cycle, registered read
// data), then pops one level per dedent item, one per cycle unless the output stalls.
// Items are handled one at a time; the output register holds a finished item so that the
// next line is taken while that item waits.
module indent_dedent_tracker #(
  parameter int STACK_DEPTH = 16,
  parameter int INDENT_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [INDENT_BITS-1:0]           line_indent_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [itdt_pkg::KIND_W-1:0]      token_kind_o,
  output logic                             last_of_run_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0] open_depth_o
);

  import itdt_pkg::*;

  `include "indent_dedent_tracker_assert.svh"

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);

  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [INDENT_BITS-1:0] rd_data;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [INDENT_BITS-1:0] wr_data;
  logic                   res_vld;
  res_t                   res;
  logic [CNT_W-1:0]       res_depth;
  logic                   res_rdy;

  itdt_mem #(
    .STACK_DEPTH(STACK_DEPTH),
    .INDENT_BITS(INDENT_BITS)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  itdt_ctrl #(
    .STACK_DEPTH(STACK_DEPTH),
    .INDENT_BITS(INDENT_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .line_indent_i(line_indent_i),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .res_vld_o    (res_vld),
    .res_o        (res),
    .res_depth_o  (res_depth),
    .res_rdy_i    (res_rdy)
  );

  itdt_out #(
    .CNT_W(CNT_W)
  ) u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_vld_i    (res_vld),
    .res_i        (res),
    .res_depth_i  (res_depth),
    .res_rdy_o    (res_rdy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .token_kind_o (token_kind_o),
    .last_of_run_o(last_of_run_o),
    .open_depth_o (open_depth_o)
  );

  `ITDT_ASSERT(busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o, "item accepted while busy")
  `ITDT_ASSERT(depth_in_range, out_valid_o |-> (open_depth_o != '0 && open_depth_o <= CNT_W'(STACK_DEPTH)), "open depth out of range")
  `ITDT_ASSERT(single_is_last, (out_valid_o && token_kind_o != KIND_DEDENT) |-> last_of_run_o, "single result not marked last")
  `ITDT_ASSERT(no_write_during_scan, (rd_en && wr_en) |-> 1'b0, "stack read and write in one cycle")

endmodule
